// ===== rtl/sijb_pkg.sv =====
package sijb_pkg;

   // Defaults for the top-level parameters
   localparam int SLOTS_DEFAULT       = 64;
   localparam int MAX_PAYLOAD_DEFAULT = 1500;

   // Field widths
   localparam int SEQ_W   = 16;
   localparam int STAMP_W = 32;
   localparam int LEN_W   = 11;
   localparam int REF_W   = 16;
   localparam int LOSS_W  = 32;

   // Request opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   // One slot of the packet table
   typedef struct packed {
      logic               used;
      logic [SEQ_W-1:0]   seq;
      logic [STAMP_W-1:0] stamp;
      logic [LEN_W-1:0]   len;
      logic [REF_W-1:0]   pay_ref;
   } slot_type;

   // Slot memory strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUOT,
      ST_INDEX,
      ST_CHECK
   } state_type;

endpackage

// ===== rtl/sijb_slot_index.sv =====
// Sequence number to slot index (seq mod SLOTS), two register stages.
// Reciprocal multiply gives a quotient at most one low; one compare-subtract fixes it.
module sijb_slot_index #(
   parameter int SLOTS = sijb_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic [sijb_pkg::SEQ_W-1:0]     key_in,
   output logic [$clog2(SLOTS)-1:0]       idx_out
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int SHIFT = sijb_pkg::SEQ_W + IDX_W;
   localparam longint unsigned MUL = (64'd1 << SHIFT) / SLOTS;
   localparam int MUL_W  = sijb_pkg::SEQ_W + 1;
   localparam int P1_W   = sijb_pkg::SEQ_W + MUL_W;
   localparam int Q_W    = P1_W - SHIFT;
   localparam int P2_W   = sijb_pkg::SEQ_W + 2;
   localparam int R_W    = sijb_pkg::SEQ_W + 1;

   localparam logic [MUL_W-1:0] MUL_V   = MUL_W'(MUL);
   localparam logic [R_W-1:0]   SLOTS_V = R_W'(SLOTS);

   logic [P1_W-1:0]            prod1_ff, prod1_in;
   logic [sijb_pkg::SEQ_W-1:0] key1_ff, key2_ff;
   logic [P2_W-1:0]            prod2_ff, prod2_in;
   logic [Q_W-1:0]             quot;
   logic [R_W-1:0]             rem_raw, rem_fix;

   assign prod1_in = P1_W'(key_in) * P1_W'(MUL_V);
   assign quot     = prod1_ff[P1_W-1:SHIFT];
   assign prod2_in = P2_W'(quot) * P2_W'(SLOTS);

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      key1_ff  <= key_in;
      prod2_ff <= prod2_in;
      key2_ff  <= key1_ff;
   end

   assign rem_raw = R_W'(key2_ff) - prod2_ff[R_W-1:0];
   assign rem_fix = (rem_raw >= SLOTS_V) ? (rem_raw - SLOTS_V) : rem_raw;
   assign idx_out = rem_fix[IDX_W-1:0];

endmodule

// ===== rtl/sijb_slot_mem.sv =====
// Packet slot table, one port, registered read.
module sijb_slot_mem #(
   parameter int SLOTS = sijb_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  sijb_pkg::mem_ctl_type      ctl,
   input  logic [$clog2(SLOTS)-1:0]   addr,
   input  sijb_pkg::slot_type         wr_data,
   output sijb_pkg::slot_type         rd_data
);

   sijb_pkg::slot_type mem [SLOTS];
   sijb_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/seq_indexed_jitter_buffer.sv =====
// Jitter buffer, sequence-indexed packet slots held in one single-port memory.
// Insert steps per request: accept, quotient stage, slot write.
// Pop steps to the result register: accept, quotient, slot read, check and
//   write-back; rsp_valid rises with the result register, and no request is
//   taken meanwhile. The two-stage modulo unit and registered read set the pace.
// Reset (synchronous): clears control, then a pass over all SLOTS entries clears every slot.
module seq_indexed_jitter_buffer #(
   parameter int SLOTS       = sijb_pkg::SLOTS_DEFAULT,
   parameter int MAX_PAYLOAD = sijb_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic [sijb_pkg::SEQ_W-1:0]     req_seq_num,
   input  logic [sijb_pkg::STAMP_W-1:0]   req_time_stamp,
   input  logic [sijb_pkg::LEN_W-1:0]     req_payload_len,
   input  logic [sijb_pkg::REF_W-1:0]     req_payload_ref,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_pkt_found,
   output logic [sijb_pkg::SEQ_W-1:0]     rsp_out_seq,
   output logic [sijb_pkg::STAMP_W-1:0]   rsp_out_time,
   output logic [sijb_pkg::LEN_W-1:0]     rsp_out_len,
   output logic [sijb_pkg::REF_W-1:0]     rsp_out_ref,
   output logic [sijb_pkg::LOSS_W-1:0]    rsp_lost_count
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0]              LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [sijb_pkg::LEN_W-1:0]    MAX_LEN  = sijb_pkg::LEN_W'(MAX_PAYLOAD);
   localparam logic [sijb_pkg::LOSS_W-1:0]   LOSS_MAX = '1;

   // ---------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------
   sijb_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]              clr_idx_ff, clr_idx_in;
   logic                          started_ff, started_in;
   logic [sijb_pkg::SEQ_W-1:0]    expected_ff, expected_in;
   logic [sijb_pkg::LOSS_W-1:0]   loss_ff, loss_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Request capture (payload, no reset)
   logic                          op_ff;
   logic [sijb_pkg::SEQ_W-1:0]    seq_ff;
   logic [sijb_pkg::STAMP_W-1:0]  stamp_ff;
   logic [sijb_pkg::LEN_W-1:0]    len_ff;
   logic [sijb_pkg::REF_W-1:0]    ref_ff;
   logic [IDX_W-1:0]              idx_ff;

   // Result register (payload)
   logic                          rsp_hit_ff;
   logic [sijb_pkg::SEQ_W-1:0]    rsp_seq_ff;
   logic [sijb_pkg::STAMP_W-1:0]  rsp_stamp_ff;
   logic [sijb_pkg::LEN_W-1:0]    rsp_len_ff;
   logic [sijb_pkg::REF_W-1:0]    rsp_ref_ff;
   logic [sijb_pkg::LOSS_W-1:0]   rsp_loss_ff;

   // Datapath glue
   logic                          accept;
   logic                          out_free;
   logic                          check_go;
   logic                          hit;
   logic [sijb_pkg::SEQ_W-1:0]    key;
   logic [IDX_W-1:0]              calc_idx;
   logic [IDX_W-1:0]              mem_addr;
   sijb_pkg::mem_ctl_type         mem_ctl;
   sijb_pkg::slot_type            mem_wr;
   sijb_pkg::slot_type            mem_rd;
   logic [sijb_pkg::LEN_W-1:0]    len_sat;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign check_go = (state_ff == sijb_pkg::ST_CHECK) && out_free;

   // Pops index by the expected number, inserts by their own.
   assign key = (req_op == sijb_pkg::OP_POP) ? expected_ff : req_seq_num;

   // Oversized lengths clamp before storage.
   assign len_sat = (req_payload_len > MAX_LEN) ? MAX_LEN : req_payload_len;

   // Found only when the slot is live and actually carries the expected number
   // (a newer packet may have overwritten it).
   assign hit = started_ff && mem_rd.used && (mem_rd.seq == expected_ff);

   sijb_slot_index #(
      .SLOTS (SLOTS)
   ) u_index (
      .clock   (clock),
      .key_in  (key),
      .idx_out (calc_idx)
   );

   sijb_slot_mem #(
      .SLOTS (SLOTS)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wr),
      .rd_data (mem_rd)
   );

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sijb_pkg::ST_CLEAR: begin
            if (clr_idx_ff == LAST_IDX) begin
               state_in = sijb_pkg::ST_IDLE;
            end
         end
         sijb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = sijb_pkg::ST_QUOT;
            end
         end
         sijb_pkg::ST_QUOT: begin
            state_in = sijb_pkg::ST_INDEX;
         end
         sijb_pkg::ST_INDEX: begin
            if (op_ff == sijb_pkg::OP_POP) begin
               state_in = sijb_pkg::ST_CHECK;
            end else begin
               state_in = sijb_pkg::ST_IDLE;
            end
         end
         sijb_pkg::ST_CHECK: begin
            if (out_free) begin
               state_in = sijb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sijb_pkg::ST_CLEAR;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // FSM outputs: handshake, memory strobes, address and write data
   // ---------------------------------------------------------------
   always_comb begin
      req_ready     = 1'b0;
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_addr      = idx_ff;
      mem_wr        = '0;
      case (state_ff)
         sijb_pkg::ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = clr_idx_ff;
         end
         sijb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         sijb_pkg::ST_QUOT: begin
            req_ready = 1'b0;
         end
         sijb_pkg::ST_INDEX: begin
            mem_addr = calc_idx;
            if (op_ff == sijb_pkg::OP_POP) begin
               mem_ctl.rd_en = 1'b1;
            end else begin
               mem_ctl.wr_en  = 1'b1;
               mem_wr.used    = 1'b1;
               mem_wr.seq     = seq_ff;
               mem_wr.stamp   = stamp_ff;
               mem_wr.len     = len_ff;
               mem_wr.pay_ref = ref_ff;
            end
         end
         sijb_pkg::ST_CHECK: begin
            // free the slot that was just delivered
            mem_ctl.wr_en = out_free && hit;
            mem_wr        = mem_rd;
            mem_wr.used   = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Control register next values
   // ---------------------------------------------------------------
   always_comb begin
      clr_idx_in   = clr_idx_ff;
      started_in   = started_ff;
      expected_in  = expected_ff;
      loss_in      = loss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (state_ff == sijb_pkg::ST_CLEAR) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
      end

      // first insert after reset sets the playout point
      if ((state_ff == sijb_pkg::ST_INDEX) && (op_ff == sijb_pkg::OP_INSERT)) begin
         started_in = 1'b1;
         if (!started_ff) begin
            expected_in = seq_ff;
         end
      end

      // pop before the first insert changes nothing but still answers
      if (check_go) begin
         rsp_valid_in = 1'b1;
         if (started_ff) begin
            expected_in = expected_ff + sijb_pkg::SEQ_W'(1);
            if (!hit && (loss_ff != LOSS_MAX)) begin
               loss_in = loss_ff + sijb_pkg::LOSS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sijb_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         started_ff   <= 1'b0;
         expected_ff  <= '0;
         loss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         started_ff   <= started_in;
         expected_ff  <= expected_in;
         loss_ff      <= loss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         seq_ff   <= req_seq_num;
         stamp_ff <= req_time_stamp;
         len_ff   <= len_sat;
         ref_ff   <= req_payload_ref;
      end
      if (state_ff == sijb_pkg::ST_INDEX) begin
         idx_ff <= calc_idx;
      end
      if (check_go) begin
         rsp_hit_ff   <= hit;
         rsp_seq_ff   <= hit ? mem_rd.seq     : '0;
         rsp_stamp_ff <= hit ? mem_rd.stamp   : '0;
         rsp_len_ff   <= hit ? mem_rd.len     : '0;
         rsp_ref_ff   <= hit ? mem_rd.pay_ref : '0;
         rsp_loss_ff  <= loss_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pkt_found  = rsp_hit_ff;
   assign rsp_out_seq    = rsp_seq_ff;
   assign rsp_out_time   = rsp_stamp_ff;
   assign rsp_out_len    = rsp_len_ff;
   assign rsp_out_ref    = rsp_ref_ff;
   assign rsp_lost_count = rsp_loss_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_rsp_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == sijb_pkg::ST_CHECK))
      else $error("result raised outside the check step");

   a_check_delivers: assert property (@(posedge clock) disable iff (reset)
      check_go |=> rsp_valid_ff)
      else $error("check step finished without a pending result");

   a_loss_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sijb_pkg::ST_CLEAR) |=> (loss_ff >= $past(loss_ff)))
      else $error("loss counter went backwards");

   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(started_ff))
      else $error("started flag dropped without reset");

   a_writeback_on_hit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sijb_pkg::ST_CHECK) && mem_ctl.wr_en) |-> (hit && !mem_ctl.rd_en))
      else $error("slot freed without a matching packet");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int SLOTS        = sijb_pkg::SLOTS_DEFAULT;
   localparam int MAX_PAYLOAD  = sijb_pkg::MAX_PAYLOAD_DEFAULT;
   localparam int SEQ_W        = sijb_pkg::SEQ_W;
   localparam int STAMP_W      = sijb_pkg::STAMP_W;
   localparam int LEN_W        = sijb_pkg::LEN_W;
   localparam int REF_W        = sijb_pkg::REF_W;
   localparam int LOSS_W       = sijb_pkg::LOSS_W;
   localparam int RANDOM_END   = 440;     // directed plus random, about 450 requests in all
   localparam int HOLDOFF      = 300;     // receiver hold-off, in cycles
   localparam int DRAIN_CYCLES = 40;      // extra wait after the last owed playout is checked
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 40;

   // One playout answer, as the block returns it
   typedef struct {
      logic               found;
      logic [SEQ_W-1:0]   seq;
      logic [STAMP_W-1:0] stamp;
      logic [LEN_W-1:0]   len;
      logic [REF_W-1:0]   handle;
      logic [LOSS_W-1:0]  lost;
   } playout_type;

   // Jitter buffer predictor plus the queue of playout answers still owed.
   class jitter_scoreboard_type;
      logic [SEQ_W-1:0]   tab_seq[SLOTS];
      logic [STAMP_W-1:0] tab_stamp[SLOTS];
      logic [LEN_W-1:0]   tab_len[SLOTS];
      logic [REF_W-1:0]   tab_handle[SLOTS];
      bit                 tab_used[SLOTS];
      logic [SEQ_W-1:0]   exp_seq;
      bit                 started;
      logic [LOSS_W-1:0]  lost;
      playout_type        playouts_due[$];
      int                 errors;

      function new();
         foreach (tab_used[i]) begin
            tab_used[i] = 0;
         end
         exp_seq = '0;
         started = 0;
         lost    = '0;
         errors  = 0;
      endfunction

      function void note_request(logic op, logic [SEQ_W-1:0] seq, logic [STAMP_W-1:0] stamp,
                                 logic [LEN_W-1:0] len, logic [REF_W-1:0] handle);
         int          idx;
         playout_type p;
         if (op == sijb_pkg::OP_INSERT) begin
            if (!started) begin
               started = 1;
               exp_seq = seq;
            end
            idx             = seq % SLOTS;
            tab_seq[idx]    = seq;
            tab_stamp[idx]  = stamp;
            tab_len[idx]    = (len > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : len;
            tab_handle[idx] = handle;
            tab_used[idx]   = 1;
            return;
         end
         p = '{found: 1'b0, seq: '0, stamp: '0, len: '0, handle: '0, lost: '0};
         if (started) begin
            idx = exp_seq % SLOTS;
            if (tab_used[idx] && tab_seq[idx] == exp_seq) begin
               p.found       = 1'b1;
               p.seq         = tab_seq[idx];
               p.stamp       = tab_stamp[idx];
               p.len         = tab_len[idx];
               p.handle      = tab_handle[idx];
               tab_used[idx] = 0;
            end else if (lost != '1) begin
               lost++;
            end
            exp_seq++;
         end
         p.lost = lost;
         playouts_due.push_back(p);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         end
      endfunction

      function void check_result(playout_type got);
         playout_type want;
         if (playouts_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: unexpected playout, expected none, got seq 0x%0h", $time, got.seq);
            return;
         end
         want = playouts_due.pop_front();
         compare_field("pkt_found", 32'(want.found), 32'(got.found));
         compare_field("out_seq", 32'(want.seq), 32'(got.seq));
         compare_field("out_time", want.stamp, got.stamp);
         compare_field("out_len", 32'(want.len), 32'(got.len));
         compare_field("out_ref", 32'(want.handle), 32'(got.handle));
         compare_field("lost_count", want.lost, got.lost);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_op = sijb_pkg::OP_INSERT;
   logic [SEQ_W-1:0]    req_seq_num = '0;
   logic [STAMP_W-1:0]  req_time_stamp = '0;
   logic [LEN_W-1:0]    req_payload_len = '0;
   logic [REF_W-1:0]    req_payload_ref = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_pkt_found;
   logic [SEQ_W-1:0]    rsp_out_seq;
   logic [STAMP_W-1:0]  rsp_out_time;
   logic [LEN_W-1:0]    rsp_out_len;
   logic [REF_W-1:0]    rsp_out_ref;
   logic [LOSS_W-1:0]   rsp_lost_count;

   jitter_scoreboard_type sb = new();

   int req_idle_pct  = 32;   // chance in 100 that the sender idles a cycle
   int rsp_idle_pct  = 32;   // same for the receiver
   int holdoff_req   = 0;    // bumped by the sender side to ask for a long hold-off
   int holdoff_done  = 0;
   int requests_sent = 0;
   int cycles        = 0;

   seq_indexed_jitter_buffer uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_seq_num    (req_seq_num),
      .req_time_stamp (req_time_stamp),
      .req_payload_len(req_payload_len),
      .req_payload_ref(req_payload_ref),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pkt_found  (rsp_pkt_found),
      .rsp_out_seq    (rsp_out_seq),
      .rsp_out_time   (rsp_out_time),
      .rsp_out_len    (rsp_out_len),
      .rsp_out_ref    (rsp_out_ref),
      .rsp_lost_count (rsp_lost_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. Covers the slot clearing pass after reset, the hold-off and all
   // random stalls many times over.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one request and hold it until accepted. Called right after a rising
   // edge; random idle cycles go in front so gaps land on every pipeline phase.
   // valid gets exactly one NBA per time step: lowered only for an idle cycle.
   task automatic send_request(logic op, logic [SEQ_W-1:0] seq, logic [STAMP_W-1:0] stamp,
                               logic [LEN_W-1:0] len, logic [REF_W-1:0] handle);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_seq_num     <= seq;
      req_time_stamp  <= stamp;
      req_payload_len <= len;
      req_payload_ref <= handle;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(op, seq, stamp, len, handle);
      requests_sent++;
   endtask

   task automatic send_insert(logic [SEQ_W-1:0] seq, logic [STAMP_W-1:0] stamp,
                              logic [LEN_W-1:0] len, logic [REF_W-1:0] handle);
      send_request(sijb_pkg::OP_INSERT, seq, stamp, len, handle);
   endtask

   // Pop carries random junk in the packet fields; the block must ignore it.
   task automatic send_pop();
      send_request(sijb_pkg::OP_POP, SEQ_W'($urandom), STAMP_W'($urandom),
                   LEN_W'($urandom), REF_W'($urandom));
   endtask

   // Mostly legal lengths, one in ten above the cap to exercise saturation.
   function automatic logic [LEN_W-1:0] rand_len();
      if ($urandom_range(99) < 10)
         return LEN_W'($urandom_range(MAX_PAYLOAD + 1, 2 ** LEN_W - 1));
      return LEN_W'($urandom_range(0, MAX_PAYLOAD));
   endfunction

   task automatic send_random_insert(logic [SEQ_W-1:0] seq);
      send_insert(seq, STAMP_W'($urandom), rand_len(), REF_W'($urandom));
   endtask

   // Receiver: checks every accepted playout against the oldest one owed, then
   // picks rsp_ready for the next cycle. A hold-off request parks it for
   // the hold-off so the block backs up and throttles req_ready.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready)
            sb.check_result('{rsp_pkt_found, rsp_out_seq, rsp_out_time, rsp_out_len,
                              rsp_out_ref, rsp_lost_count});
         if (holdoff_req != holdoff_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLDOFF) @(posedge clock);
            holdoff_done++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      logic [SEQ_W-1:0] seqs[$];
      logic [SEQ_W-1:0] tmp;
      logic [SEQ_W-1:0] base;
      int               n;
      int               pops;
      int               pick;
      bit               pressed;

      pressed = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ---- Directed part ----
      // Pops before any insert: no packet, count untouched, state untouched.
      send_pop();
      send_pop();
      // First insert latches the expected sequence number near the 16-bit wrap.
      // All-ones fields; length 2047 must be stored as the cap.
      send_insert(16'hFFFC, 32'hFFFF_FFFF, 11'h7FF, 16'hFFFF);
      send_insert(16'hFFFD, 32'h0000_0000, 11'h000, 16'h0000);
      send_insert(16'hFFFE, 32'hA5A5_5A5A, 11'd1500, 16'h5A5A);
      // Same slot as FFFE, other sequence number: silent overwrite.
      send_insert(16'h003E, 32'h5A5A_A5A5, 11'd1501, 16'hA5A5);
      send_insert(16'hFFFF, 32'h8000_0001, 11'h400, 16'h8001);
      send_insert(16'h0000, 32'h7FFF_FFFE, 11'h3FF, 16'h7FFE);
      send_insert(16'h0001, 32'h1234_5678, 11'd1, 16'h0001);
      // FFFC, FFFD hit; FFFE misses on the collision; FFFF, 0000, 0001 hit
      // across the wrap; 0002 was never sent.
      repeat (7) send_pop();
      // Late packet far behind the playout point, then one in time.
      send_insert(16'hFFFD, 32'hDEAD_BEEF, 11'd64, 16'h00FF);
      send_insert(16'h0003, 32'h0F0F_0F0F, 11'd700, 16'hFF00);
      send_pop();
      send_pop();
      // Duplicate: the later copy wins.
      send_insert(16'h0005, 32'h1111_1111, 11'd100, 16'h1111);
      send_insert(16'h0005, 32'h2222_2222, 11'd200, 16'h2222);
      send_pop();   // expected 0005 after the miss on 0004
      send_pop();

      // ---- Random part ----
      while (requests_sent < RANDOM_END) begin
         // Stretch with no idling on either side.
         if (requests_sent >= 100 && requests_sent < 180) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 32;
            rsp_idle_pct = 32;
         end

         // Once: receiver parks while the sender streams with no gaps.
         if (!pressed && requests_sent >= 250) begin
            pressed      = 1;
            req_idle_pct = 0;
            holdoff_req++;
            base = sb.exp_seq;
            for (int i = 0; i < 10; i++) send_random_insert(base + SEQ_W'(i));
            repeat (24) send_pop();
            req_idle_pct = 32;
         end

         pick = $urandom_range(99);
         if (pick < 75) begin
            // Well-formed burst around the playout point: a run of packets with
            // some lost, duplicated and swapped, then roughly as many pops.
            base = sb.exp_seq;
            n    = $urandom_range(1, 12);
            seqs.delete();
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(99) >= 10) seqs.push_back(base + SEQ_W'(i));
               if ($urandom_range(99) < 5)  seqs.push_back(base + SEQ_W'(i));
            end
            for (int i = 0; i + 1 < seqs.size(); i++) begin
               if ($urandom_range(99) < 25) begin
                  tmp         = seqs[i];
                  seqs[i]     = seqs[i + 1];
                  seqs[i + 1] = tmp;
               end
            end
            foreach (seqs[i]) send_random_insert(seqs[i]);
            pops = $urandom_range((n > 2) ? n - 2 : 0, n + 2);
            repeat (pops) send_pop();
         end else if (pick < 82) begin
            send_random_insert(SEQ_W'($urandom));                          // anywhere
         end else if (pick < 88) begin
            send_random_insert(sb.exp_seq - SEQ_W'($urandom_range(1, 70))); // late
         end else if (pick < 93) begin
            // Ahead by whole table turns: lands on the expected slot, wrong seq.
            send_random_insert(sb.exp_seq + SEQ_W'(SLOTS * $urandom_range(1, 4)));
         end else begin
            send_pop();
         end
      end

      // ---- Drain ----
      req_valid <= 1'b0;
      while (sb.playouts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
